>>> src/delimited_line_field_splitter_macros.svh
// Assertion helpers shared by the splitter modules.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef DELIMITED_LINE_FIELD_SPLITTER_MACROS_SVH
`define DELIMITED_LINE_FIELD_SPLITTER_MACROS_SVH

// Same-cycle implication.
`define DLFS_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dlfs: same-cycle check failed");

// Next-cycle implication.
`define DLFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dlfs: next-cycle check failed");

`endif

>>> src/dlfs_pkg.sv
`timescale 1ns / 1ps

package dlfs_pkg;

   localparam int SELECT_WIDTH_DEFAULT = 64;
   localparam int FIELD_LIMIT_DEFAULT  = 1024;

   localparam int BYTE_WIDTH        = 8;
   localparam int KIND_WIDTH        = 2;
   localparam int FIELD_INDEX_WIDTH = 10;
   localparam int FIELD_COUNT_WIDTH = 11;
   localparam int CSR_INDEX_WIDTH   = 8;
   localparam int CSR_DATA_WIDTH    = 64;

   localparam logic [BYTE_WIDTH-1:0] CHAR_TAB = 8'h09;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LF  = 8'h0a;
   localparam logic [BYTE_WIDTH-1:0] CHAR_CR  = 8'h0d;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELIMITER     = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLUMN_SELECT = 8'd1;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_DATA      = 2'd0,
      KIND_FIELD_END = 2'd1,
      KIND_LINE_END  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                       kind;
      logic [BYTE_WIDTH-1:0]          data_byte;
      logic [FIELD_INDEX_WIDTH-1:0]   field_index;
      logic [FIELD_COUNT_WIDTH-1:0]   field_count;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } result_type;

endpackage

>>> src/dlfs_if.sv
`timescale 1ns / 1ps

interface dlfs_req_if;
   logic                             valid;
   logic                             ready;
   logic [dlfs_pkg::BYTE_WIDTH-1:0]  text_byte;
   logic                             end_of_stream;

   modport source (output valid, output text_byte, output end_of_stream, input ready);
   modport sink   (input valid, input text_byte, input end_of_stream, output ready);
endinterface

interface dlfs_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [dlfs_pkg::KIND_WIDTH-1:0]         kind;
   logic [dlfs_pkg::BYTE_WIDTH-1:0]         data_byte;
   logic [dlfs_pkg::FIELD_INDEX_WIDTH-1:0]  field_index;
   logic [dlfs_pkg::FIELD_COUNT_WIDTH-1:0]  field_count;

   modport source (output valid, output kind, output data_byte, output field_index,
                   output field_count, input ready);
   modport sink   (input valid, input kind, input data_byte, input field_index,
                   input field_count, output ready);
endinterface

interface dlfs_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [dlfs_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [dlfs_pkg::CSR_DATA_WIDTH-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/delimited_line_field_splitter.sv
`timescale 1ns / 1ps
// Line and field splitter for delimited text, one byte per transaction.
// req_if carries text_byte or an end_of_stream marker; rsp_if returns data
// bytes of selected fields, field-end marks and line-end marks with the
// field count. csr_if writes register 0 (delimiter) and 1 (column_select);
// it is always ready and should only be written while the block is idle.
// A result reaches rsp_if through the result register, or the skid entry when that is full.
// Throughput: one request per clock; the per-byte classification is a
// single combinational pass between the parser state and the result
// register, so nothing limits the rate but the result channel.
// Many requests produce no result (swallowed LF, unselected bytes).
// Reset (synchronous): delimiter returns to tab, every column is selected,
// the line state clears and the result register empties.
// Receiver stall: the result register plus one skid entry absorb a stall;
// req_if.ready drops once the skid entry is occupied and rises again the
// cycle after the receiver takes a result.
module delimited_line_field_splitter #(
   parameter int SELECT_WIDTH = dlfs_pkg::SELECT_WIDTH_DEFAULT,
   parameter int FIELD_LIMIT  = dlfs_pkg::FIELD_LIMIT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   dlfs_req_if.sink    req_if,
   dlfs_rsp_if.source  rsp_if,
   dlfs_csr_if.sink    csr_if
);
   import dlfs_pkg::*;

   logic       stage_ready;
   logic       req_accept;
   result_type result;

   // a request transaction completes whenever the skid entry is free
   assign req_if.ready = stage_ready;
   assign req_accept   = req_if.valid & req_if.ready;

   // byte classification, line state and configuration registers
   dlfs_parser #(
      .SELECT_WIDTH (SELECT_WIDTH),
      .FIELD_LIMIT  (FIELD_LIMIT)
   ) u_parser (
      .clock             (clock),
      .reset             (reset),
      .csr_port          (csr_if),
      .req_accept        (req_accept),
      .req_text_byte     (req_if.text_byte),
      .req_end_of_stream (req_if.end_of_stream),
      .result            (result)
   );

   // result register with one skid entry
   dlfs_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .in_item  (result),
      .in_ready (stage_ready),
      .rsp_port (rsp_if)
   );

endmodule

>>> src/dlfs_parser.sv
`timescale 1ns / 1ps
`include "delimited_line_field_splitter_macros.svh"

module dlfs_parser #(
   parameter int SELECT_WIDTH = dlfs_pkg::SELECT_WIDTH_DEFAULT,
   parameter int FIELD_LIMIT  = dlfs_pkg::FIELD_LIMIT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   dlfs_csr_if.sink                         csr_port,
   input  logic                             req_accept,
   input  logic [dlfs_pkg::BYTE_WIDTH-1:0]  req_text_byte,
   input  logic                             req_end_of_stream,
   output dlfs_pkg::result_type             result
);
   import dlfs_pkg::*;

   localparam int FW     = $clog2(FIELD_LIMIT);
   localparam int SEL_IW = (SELECT_WIDTH > 1) ? $clog2(SELECT_WIDTH) : 1;
   localparam logic [FW-1:0] LAST_FIELD = FW'(FIELD_LIMIT - 1);
   localparam logic [FW:0]   SELECT_END = (FW + 1)'(SELECT_WIDTH);

   logic [BYTE_WIDTH-1:0]   delimiter_ff;
   logic [SELECT_WIDTH-1:0] column_select_ff;
   logic                    csr_write;

   logic          after_cr_ff, after_cr_in;
   logic [FW-1:0] current_field_ff, current_field_in;
   logic          line_started_ff, line_started_in;

   logic                         selected;
   logic                         at_limit;
   logic [FIELD_INDEX_WIDTH-1:0] index_out;
   logic [FIELD_COUNT_WIDTH-1:0] count_out;

   // configuration registers, always writable
   assign csr_port.ready = 1'b1;
   assign csr_write      = csr_port.valid & csr_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff     <= CHAR_TAB;
         column_select_ff <= '1;
      end else if (csr_write) begin
         unique case (csr_port.index)
            CSR_DELIMITER: begin
               delimiter_ff <= csr_port.data[BYTE_WIDTH-1:0];
            end
            CSR_COLUMN_SELECT: begin
               column_select_ff <= csr_port.data[SELECT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // field lookup: indexes past the select mask are never chosen
   assign selected  = ({1'b0, current_field_ff} < SELECT_END) &&
                      column_select_ff[current_field_ff[SEL_IW-1:0]];
   assign at_limit  = (current_field_ff == LAST_FIELD);
   assign index_out = FIELD_INDEX_WIDTH'(current_field_ff);
   assign count_out = FIELD_COUNT_WIDTH'({1'b0, current_field_ff} + 1'b1);

   always_comb begin
      after_cr_in      = after_cr_ff;
      current_field_in = current_field_ff;
      line_started_in  = line_started_ff;
      result           = '0;
      result.payload.field_index = index_out;
      if (req_accept) begin
         if (req_end_of_stream) begin
            after_cr_in      = 1'b0;
            current_field_in = '0;
            line_started_in  = 1'b0;
            if (line_started_ff) begin
               result.valid               = 1'b1;
               result.payload.kind        = KIND_LINE_END;
               result.payload.field_count = count_out;
            end
         end else if (req_text_byte == delimiter_ff) begin
            after_cr_in     = 1'b0;
            line_started_in = 1'b1;
            if (!at_limit) begin
               current_field_in = current_field_ff + 1'b1;
               if (selected) begin
                  result.valid        = 1'b1;
                  result.payload.kind = KIND_FIELD_END;
               end
            end
         end else if (after_cr_ff && (req_text_byte == CHAR_LF)) begin
            // LF of a CR LF pair
            after_cr_in = 1'b0;
         end else if ((req_text_byte == CHAR_CR) || (req_text_byte == CHAR_LF)) begin
            after_cr_in      = (req_text_byte == CHAR_CR);
            current_field_in = '0;
            line_started_in  = 1'b0;
            result.valid               = 1'b1;
            result.payload.kind        = KIND_LINE_END;
            result.payload.field_count = count_out;
         end else begin
            after_cr_in     = 1'b0;
            line_started_in = 1'b1;
            if (selected) begin
               result.valid             = 1'b1;
               result.payload.kind      = KIND_DATA;
               result.payload.data_byte = req_text_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_cr_ff      <= 1'b0;
         current_field_ff <= '0;
         line_started_ff  <= 1'b0;
      end else begin
         after_cr_ff      <= after_cr_in;
         current_field_ff <= current_field_in;
         line_started_ff  <= line_started_in;
      end
   end

   `DLFS_ASSERT_IMPLIES(a_after_cr_fresh_line, after_cr_ff,
      (current_field_ff == '0) && !line_started_ff)
   `DLFS_ASSERT_IMPLIES(a_field_in_range, 1'b1, current_field_ff <= LAST_FIELD)
   `DLFS_ASSERT_NEXT(a_eos_clears, req_accept && req_end_of_stream,
      (current_field_ff == '0) && !line_started_ff && !after_cr_ff)

endmodule

>>> src/dlfs_out_stage.sv
`timescale 1ns / 1ps
`include "delimited_line_field_splitter_macros.svh"

module dlfs_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  dlfs_pkg::result_type  in_item,
   output logic                  in_ready,
   dlfs_rsp_if.source            rsp_port
);
   import dlfs_pkg::*;

   rsp_payload_type main_ff, main_in;
   rsp_payload_type skid_ff, skid_in;
   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   logic            take_out;

   assign in_ready = ~skid_valid_ff;
   assign take_out = main_valid_ff & rsp_port.ready;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (take_out) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = 1'b0;
         end
      end
      if (in_item.valid) begin
         if (!main_valid_in) begin
            main_in       = in_item.payload;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_item.payload;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_port.valid       = main_valid_ff;
   assign rsp_port.kind        = main_ff.kind;
   assign rsp_port.data_byte   = main_ff.data_byte;
   assign rsp_port.field_index = main_ff.field_index;
   assign rsp_port.field_count = main_ff.field_count;

   `DLFS_ASSERT_IMPLIES(a_skid_behind_main, skid_valid_ff, main_valid_ff)
   `DLFS_ASSERT_NEXT(a_skid_drains, skid_valid_ff && rsp_port.ready,
      main_valid_ff && !skid_valid_ff)
   `DLFS_ASSERT_NEXT(a_empty_loads, in_item.valid && !main_valid_ff, main_valid_ff)

endmodule

>>> tb/sv/delimited_line_field_splitter_tb.sv
`timescale 1ns / 1ps

module delimited_line_field_splitter_tb;
   import dlfs_pkg::*;

   localparam int SEL_W   = SELECT_WIDTH_DEFAULT;
   localparam int FLD_LIM = FIELD_LIMIT_DEFAULT;
   // column_select keeps only the low SEL_W bits
   localparam logic [CSR_DATA_WIDTH-1:0] SELECT_MASK =
      (SEL_W >= 64) ? {CSR_DATA_WIDTH{1'b1}} : ((64'd1 << SEL_W) - 64'd1);
   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_PER_PHASE = 50;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] text_byte;
      logic                  end_of_stream;
   } text_item_type;

   logic clock;
   logic reset;

   dlfs_req_if req_if ();
   dlfs_rsp_if rsp_if ();
   dlfs_csr_if csr_if ();

   delimited_line_field_splitter #(
      .SELECT_WIDTH (SEL_W),
      .FIELD_LIMIT  (FLD_LIM)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // ---------------------------------------------------------------------
   // Splitter state as the testbench tracks it. Configuration copies are
   // updated when a CSR transaction lands; line state on every accepted
   // request transaction.
   // ---------------------------------------------------------------------
   logic [BYTE_WIDTH-1:0]        split_delim;
   logic [CSR_DATA_WIDTH-1:0]    split_select;
   logic                         split_after_cr;
   logic [FIELD_INDEX_WIDTH-1:0] split_field;
   logic                         split_line_open;

   text_item_type   text_queue[$];      // bytes waiting for the driver
   rsp_payload_type expected_tokens[$]; // tokens the splitter still owes us
   text_item_type   next_item;

   int unsigned items_queued;
   int unsigned items_sent;
   int unsigned items_taken;
   int          errors;
   int          cycles;
   int          send_idle_pct;
   int          recv_idle_pct;

   // fields at or above SEL_W can never be selected
   function automatic bit column_on(input logic [FIELD_INDEX_WIDTH-1:0] idx);
      if (int'(idx) >= SEL_W)
         return 1'b0;
      return split_select[idx];
   endfunction

   // Advance the line state by one request and queue the token it yields.
   task automatic split_byte(input logic [BYTE_WIDTH-1:0] b, input logic eos);
      logic [FIELD_INDEX_WIDTH-1:0] idx;
      rsp_payload_type              tok;
      bit                           emit;
      idx             = split_field;
      tok             = '0;
      tok.field_index = idx;
      emit            = 1'b0;
      if (eos) begin
         // end of stream: flush a pending line, then start clean
         emit            = split_line_open;
         split_after_cr  = 1'b0;
         split_field     = '0;
         split_line_open = 1'b0;
         tok.kind        = KIND_LINE_END;
         tok.field_count = FIELD_COUNT_WIDTH'(idx) + 1'b1;
      end else if (b == split_delim) begin
         // delimiter wins over CR/LF; at the field limit it is dropped
         split_after_cr  = 1'b0;
         split_line_open = 1'b1;
         if (int'(idx) < FLD_LIM - 1) begin
            split_field = idx + 1'b1;
            emit        = column_on(idx);
            tok.kind    = KIND_FIELD_END;
         end
      end else if (split_after_cr && b == CHAR_LF) begin
         split_after_cr = 1'b0; // LF of a CRLF pair: swallowed
      end else if (b == CHAR_CR || b == CHAR_LF) begin
         split_after_cr  = (b == CHAR_CR);
         split_field     = '0;
         split_line_open = 1'b0;
         emit            = 1'b1;
         tok.kind        = KIND_LINE_END;
         tok.field_count = FIELD_COUNT_WIDTH'(idx) + 1'b1;
      end else begin
         split_after_cr  = 1'b0;
         split_line_open = 1'b1;
         emit            = column_on(idx);
         tok.kind        = KIND_DATA;
         tok.data_byte   = b;
      end
      if (emit)
         expected_tokens.push_back(tok);
   endtask

   function automatic bit field_bad(input string name, input logic [15:0] exp_v,
                                    input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic check_token();
      rsp_payload_type exp_tok;
      if (expected_tokens.size() == 0) begin
         $display("%0t: unexpected transaction, expected none actual kind %0h byte %0h",
                  $time, rsp_if.kind, rsp_if.data_byte);
         $display("%0t:    field_index %0d field_count %0d", $time, rsp_if.field_index,
                  rsp_if.field_count);
         errors++;
      end else begin
         exp_tok = expected_tokens.pop_front();
         errors += field_bad("kind", 16'(exp_tok.kind), 16'(rsp_if.kind));
         errors += field_bad("data_byte", 16'(exp_tok.data_byte), 16'(rsp_if.data_byte));
         errors += field_bad("field_index", 16'(exp_tok.field_index),
                             16'(rsp_if.field_index));
         errors += field_bad("field_count", 16'(exp_tok.field_count),
                             16'(rsp_if.field_count));
      end
   endtask

   // ---------------------------------------------------------------------
   // Clock, reset, watchdog
   // ---------------------------------------------------------------------
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[delimited_line_field_splitter] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request driver: pulls from text_queue, holds a transaction until
   // ready, and runs the prediction at the accepting edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid         <= 1'b0;
         req_if.text_byte     <= '0;
         req_if.end_of_stream <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            split_byte(req_if.text_byte, req_if.end_of_stream);
            items_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (text_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = text_queue.pop_front();
               items_sent++;
               req_if.valid         <= 1'b1;
               req_if.text_byte     <= next_item.text_byte;
               req_if.end_of_stream <= next_item.end_of_stream;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor with random back-pressure.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            check_token();
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_byte(input logic [BYTE_WIDTH-1:0] b);
      text_queue.push_back(text_item_type'{text_byte: b, end_of_stream: 1'b0});
      items_queued++;
   endtask

   task automatic push_eos();
      // the byte lane carries junk: it must be ignored
      text_queue.push_back(text_item_type'{text_byte: BYTE_WIDTH'($urandom_range(0, 255)),
                                           end_of_stream: 1'b1});
      items_queued++;
   endtask

   // any byte that is plain field content under the current delimiter
   function automatic logic [BYTE_WIDTH-1:0] plain_byte();
      logic [BYTE_WIDTH-1:0] b;
      do
         b = BYTE_WIDTH'($urandom_range(0, 255));
      while (b == split_delim || b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   // One well-formed line with random content and a random terminator.
   // Occasionally wide enough to run past the selectable columns.
   task automatic add_line();
      int nfields;
      int len;
      int term;
      nfields = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
      for (int f = 0; f < nfields; f++) begin
         len = $urandom_range(0, 5);
         for (int k = 0; k < len; k++)
            push_byte(plain_byte());
         if (f < nfields - 1)
            push_byte(split_delim);
      end
      term = $urandom_range(0, 9);
      case (term)
         0, 1, 2, 3: push_byte(CHAR_LF);
         4, 5: push_byte(CHAR_CR);
         6, 7: begin
            push_byte(CHAR_CR);
            push_byte(CHAR_LF);
         end
         8: push_eos();
         default: ; // unterminated: runs into the next line
      endcase
   endtask

   task automatic fill_random(input int unsigned n);
      int unsigned goal;
      int          burst;
      goal = items_queued + n;
      while (items_queued < goal) begin
         if ($urandom_range(0, 7) == 0) begin
            // noise: raw bytes, stray terminators, stray end-of-stream
            burst = $urandom_range(1, 4);
            for (int k = 0; k < burst; k++) begin
               if ($urandom_range(0, 15) == 0)
                  push_eos();
               else
                  push_byte(BYTE_WIDTH'($urandom_range(0, 255)));
            end
         end else begin
            add_line();
         end
      end
   endtask

   // Line with more delimiters than the field limit allows; the count
   // must saturate and the extra delimiters vanish.
   task automatic add_long_line();
      for (int k = 0; k < FLD_LIM + 6; k++)
         push_byte(split_delim);
      for (int k = 0; k < 3; k++)
         push_byte(plain_byte());
      push_byte(CHAR_LF);
   endtask

   task automatic wait_quiet();
      while (!(text_queue.size() == 0 && items_sent == items_taken &&
               expected_tokens.size() == 0))
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do
         @(posedge clock);
      while (!csr_if.ready);
      if (idx == CSR_DELIMITER)
         split_delim = data[BYTE_WIDTH-1:0];
      else if (idx == CSR_COLUMN_SELECT)
         split_select = data & SELECT_MASK;
      csr_if.valid <= 1'b0;
   endtask

   // Reconfigure while idle, then two halves of random traffic with a
   // full drain in between (sender holds off until every token is back).
   task automatic run_phase(input logic [BYTE_WIDTH-1:0] delim,
                            input logic [CSR_DATA_WIDTH-1:0] sel,
                            input int send_pct, input int recv_pct, input bit long_line);
      wait_quiet();
      // requests that produce no token may still be in the pipe
      repeat (4) @(posedge clock);
      write_csr(CSR_DELIMITER, delim);
      write_csr(CSR_COLUMN_SELECT, sel);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (long_line)
         add_long_line();
      fill_random(RANDOM_PER_PHASE / 2);
      wait_quiet();
      fill_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.text_byte     = '0;
      req_if.end_of_stream = 1'b0;
      rsp_if.ready         = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.index         = '0;
      csr_if.data          = '0;
      errors               = 0;
      cycles               = 0;
      items_queued         = 0;
      items_sent           = 0;
      items_taken          = 0;
      send_idle_pct        = 21;
      recv_idle_pct        = 45;
      // reset values of the splitter
      split_delim          = CHAR_TAB;
      split_select         = SELECT_MASK;
      split_after_cr       = 1'b0;
      split_field          = '0;
      split_line_open      = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed pass on reset configuration (tab, all columns).
      push_byte(8'h61);       // plain two-field line, CRLF ended
      push_byte(CHAR_TAB);
      push_byte(8'h62);
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
      push_byte(CHAR_LF);     // bare LF: empty line, count 1
      push_byte(CHAR_CR);     // CR CR LF: two line ends, LF swallowed
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
      push_byte(8'h00);       // control and top bytes are data
      push_byte(8'hff);
      push_byte(CHAR_TAB);    // empty fields
      push_byte(CHAR_TAB);
      push_byte(CHAR_LF);
      push_byte(8'h78);       // end of stream with a pending line
      push_eos();
      push_eos();             // end of stream with nothing pending
      push_byte(CHAR_CR);     // end of stream clears CR memory
      push_eos();
      push_byte(CHAR_LF);
      push_byte(CHAR_CR);     // delimiter clears CR memory
      push_byte(CHAR_TAB);
      push_byte(CHAR_LF);

      // sender 21 / receiver 45
      run_phase(8'h2c, {$urandom, $urandom}, 21, 45, 1'b0);
      run_phase(CHAR_TAB, SELECT_MASK, 21, 45, 1'b1);
      // sender 45 / receiver 21
      run_phase(8'h00, '0, 45, 21, 1'b0);
      run_phase(8'hff, 64'h5555_5555_5555_5555, 45, 21, 1'b0);
      // no idling; delimiters that collide with the line terminators
      run_phase(CHAR_CR, {1'b1, 62'($urandom) << 31 | 62'($urandom), 1'b1}, 0, 0, 1'b0);
      run_phase(CHAR_LF, {$urandom, $urandom}, 0, 0, 1'b0);

      wait_quiet();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("[delimited_line_field_splitter] OK");
      else
         $display("[delimited_line_field_splitter] ERROR");
      $finish;
   end

endmodule
